[rtl/pse_pkg.sv]
// ----------------------------------------------------------------------------
// Prime sieve engine package
// Shared word types, command and status codes and default sizes.
// ----------------------------------------------------------------------------
package pse_pkg;

   localparam int DEF_MAX_N = 65536;
   localparam int LIMIT_W = 17;
   localparam int VALUE_W = 16;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

   localparam logic CMD_BUILD = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_RANGE     = 2'd1,
      ST_NOT_BUILT = 2'd2
   } status_type;

   typedef struct packed {
      logic               cmd;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic       is_prime;
      status_type status;
   } rsp_type;

endpackage

[rtl/prime_sieve_engine_core.sv]
// ----------------------------------------------------------------------------
// Prime sieve engine core
// Query: map read and pending flag registered on acceptance, result word
// register loaded once the output is free; one query per cycle while results
// drain freely and no build runs. Build: fill pass, then a read and a wait
// state per candidate and a write per multiple, on the one map port pair.
// Reset is synchronous; the map needs no clearing pass, queries before the
// first build report that the map is not built.
// ----------------------------------------------------------------------------
module prime_sieve_engine_core #(
   parameter int MAX_N = pse_pkg::DEF_MAX_N
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  pse_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output pse_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [pse_pkg::LIMIT_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(MAX_N);
   localparam int NW = $clog2(MAX_N + 1);
   localparam int LW = (NW > pse_pkg::LIMIT_W) ? NW : pse_pkg::LIMIT_W;
   localparam int VW = (NW > pse_pkg::VALUE_W) ? NW : pse_pkg::VALUE_W;

   logic [pse_pkg::LIMIT_W-1:0] limit_ff;
   logic [NW-1:0]               built_ff, built_in;
   logic                        map_built_ff, map_built_in;
   logic                        pend_ff, pend_in;
   logic                        pend_rd_ff, pend_rd_in;
   pse_pkg::status_type         pend_st_ff, pend_st_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   pse_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic [LW-1:0]  lim_ext;
   logic [NW-1:0]  eff_limit;
   logic [VW-1:0]  v_ext;
   logic [VW-1:0]  bl_ext;
   logic           accept;
   logic           out_free;
   logic           q_read;
   pse_pkg::status_type q_st;

   logic          seq_busy, seq_done, done_ack;
   logic          seq_we, seq_wd, seq_re;
   logic [AW-1:0] seq_wa, seq_ra;
   logic          ram_re, ram_rd;
   logic [AW-1:0] ram_ra;

   assign lim_ext = LW'(limit_ff);
   always_comb begin
      if (lim_ext < LW'(2)) begin
         eff_limit = NW'(2);
      end else if (lim_ext > LW'(MAX_N)) begin
         eff_limit = NW'(MAX_N);
      end else begin
         eff_limit = lim_ext[NW-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = !seq_busy && (!pend_ff || out_free);
   assign accept = req_valid && req_ready;
   assign done_ack = seq_done && out_free;

   assign v_ext = VW'(req_data.value);
   assign bl_ext = VW'(built_ff);

   always_comb begin
      q_read = 1'b0;
      if (!map_built_ff) begin
         q_st = pse_pkg::ST_NOT_BUILT;
      end else if ((v_ext == '0) || (v_ext >= bl_ext)) begin
         q_st = pse_pkg::ST_RANGE;
      end else begin
         q_st = pse_pkg::ST_OK;
         q_read = 1'b1;
      end
   end

   assign ram_re = seq_busy ? seq_re : (accept && (req_data.cmd == pse_pkg::CMD_QUERY) && q_read);
   assign ram_ra = seq_busy ? seq_ra : v_ext[AW-1:0];

   always_comb begin
      built_in = built_ff;
      map_built_in = map_built_ff;
      pend_in = pend_ff;
      pend_rd_in = pend_rd_ff;
      pend_st_in = pend_st_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_ff && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.is_prime = pend_rd_ff && ram_rd;
         rsp_data_in.status = pend_st_ff;
         pend_in = 1'b0;
      end else if (done_ack) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.is_prime = 1'b0;
         rsp_data_in.status = pse_pkg::ST_OK;
         map_built_in = 1'b1;
      end
      if (accept) begin
         if (req_data.cmd == pse_pkg::CMD_BUILD) begin
            built_in = eff_limit;
         end else begin
            pend_in = 1'b1;
            pend_rd_in = q_read;
            pend_st_in = q_st;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= pse_pkg::LIMIT_RESET;
         built_ff <= '0;
         map_built_ff <= 1'b0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         built_ff <= built_in;
         map_built_ff <= map_built_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_rd_ff <= pend_rd_in;
      pend_st_ff <= pend_st_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   pse_build_seq #(
      .MAX_N(MAX_N),
      .AW(AW),
      .NW(NW)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .start(accept && (req_data.cmd == pse_pkg::CMD_BUILD)),
      .limit(eff_limit),
      .busy(seq_busy),
      .done_valid(seq_done),
      .done_ack(done_ack),
      .wr_en(seq_we),
      .wr_addr(seq_wa),
      .wr_data(seq_wd),
      .rd_en(seq_re),
      .rd_addr(seq_ra),
      .rd_data(ram_rd)
   );

   pse_map_ram #(
      .DEPTH(MAX_N),
      .AW(AW)
   ) u_ram (
      .clock(clock),
      .wr_en(seq_we),
      .wr_addr(seq_wa),
      .wr_data(seq_wd),
      .rd_en(ram_re),
      .rd_addr(ram_ra),
      .rd_data(ram_rd)
   );

endmodule

[rtl/pse_map_ram.sv]
// ----------------------------------------------------------------------------
// Prime map memory
// One-bit-wide synchronous memory with one write port and one registered read.
// ----------------------------------------------------------------------------
module pse_map_ram #(
   parameter int DEPTH = pse_pkg::DEF_MAX_N,
   parameter int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data
);

   logic mem [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pse_build_seq.sv]
// ----------------------------------------------------------------------------
// Sieve build sequencer
// Fills the map, then walks the sieve: reads each candidate and clears its
// multiples from its square upward, waiting for each candidate's read.
// ----------------------------------------------------------------------------
module pse_build_seq #(
   parameter int MAX_N = pse_pkg::DEF_MAX_N,
   parameter int AW = $clog2(MAX_N),
   parameter int NW = $clog2(MAX_N + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] limit,
   output logic          busy,
   output logic          done_valid,
   input  logic          done_ack,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic          wr_data,
   output logic          rd_en,
   output logic [AW-1:0] rd_addr,
   input  logic          rd_data
);

   localparam int CW = NW + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FILL,
      S_CHK_RD,
      S_CHK_WT,
      S_MARK,
      S_DONE
   } state_type;

   state_type     state_ff, state_in;
   logic [NW-1:0] n_ff, n_in;
   logic [CW-1:0] a_ff, a_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] sq_ff, sq_in;
   logic [CW-1:0] n_ext;
   logic [CW-1:0] a_next;
   logic [CW-1:0] sq_next;

   assign n_ext = {1'b0, n_ff};
   assign a_next = a_ff + i_ff;
   assign sq_next = sq_ff + {i_ff[CW-2:0], 1'b1};

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      a_in = a_ff;
      i_in = i_ff;
      sq_in = sq_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_in = limit;
               a_in = '0;
               i_in = CW'(2);
               sq_in = CW'(4);
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            a_in = a_ff + CW'(1);
            if (a_ff == n_ext - CW'(1)) begin
               state_in = S_CHK_RD;
            end
         end
         S_CHK_RD: begin
            if (sq_ff >= n_ext) begin
               state_in = S_DONE;
            end else begin
               state_in = S_CHK_WT;
            end
         end
         S_CHK_WT: begin
            if (rd_data) begin
               a_in = sq_ff;
               state_in = S_MARK;
            end else begin
               i_in = i_ff + CW'(1);
               sq_in = sq_next;
               state_in = S_CHK_RD;
            end
         end
         S_MARK: begin
            a_in = a_next;
            if (a_next >= n_ext) begin
               i_in = i_ff + CW'(1);
               sq_in = sq_next;
               state_in = S_CHK_RD;
            end
         end
         S_DONE: begin
            if (done_ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff <= n_in;
      a_ff <= a_in;
      i_ff <= i_in;
      sq_ff <= sq_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign done_valid = (state_ff == S_DONE);
   assign wr_en = (state_ff == S_FILL) || (state_ff == S_MARK);
   assign wr_addr = a_ff[AW-1:0];
   assign wr_data = (state_ff == S_FILL) && (a_ff >= CW'(2));
   assign rd_en = (state_ff == S_CHK_RD) && (sq_ff < n_ext);
   assign rd_addr = i_ff[AW-1:0];

endmodule

[rtl/pse_checker.sv]
// ----------------------------------------------------------------------------
// Prime sieve engine port checker
// Watches the request and result channels of the core and is bound to it.
// ----------------------------------------------------------------------------
module pse_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input pse_pkg::req_type            req_data,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input pse_pkg::rsp_type            rsp_data
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   a_err_not_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != pse_pkg::ST_OK) |-> !rsp_data.is_prime)
      else $error("error result word flags a prime");

   a_query_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.cmd == pse_pkg::CMD_QUERY) |=> ##1 rsp_valid)
      else $error("accepted query word got no result word");

endmodule

bind prime_sieve_engine_core pse_checker u_pse_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data(req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);
